// ----- rtl/core/brst_pkg.sv -----
// ----------------------------------------------------------------------------
// Binary range split tree package
// Shared constants and types for the breadth-first range bisection core.
// ----------------------------------------------------------------------------
package brst_pkg;

   // Default depth of the split tree and default index width.
   localparam int BRST_MAX_LEVELS  = 5;
   localparam int BRST_INDEX_WIDTH = 16;

   // Width and reset value of the levels register.
   localparam int          BRST_LEVELS_WIDTH = 3;
   localparam logic [2:0]  BRST_LEVELS_RESET = 3'd3;

   // Sequencer states.
   typedef enum logic [0:0] {
      BRST_IDLE,
      BRST_RUN
   } brst_state_type;

endpackage

// ----- rtl/core/brst_req_if.sv -----
// ----------------------------------------------------------------------------
// Range request interface
// Carries one index range per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface brst_req_if #(
   parameter int INDEX_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] start_index;
   logic [INDEX_WIDTH-1:0] end_index;

   modport source (output valid, output start_index, output end_index, input ready);
   modport sink   (input valid, input start_index, input end_index, output ready);
endinterface

// ----- rtl/core/brst_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Node response interface
// Carries one tree node range per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface brst_rsp_if #(
   parameter int INDEX_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [INDEX_WIDTH-1:0] node_start;
   logic [INDEX_WIDTH-1:0] node_end;
   logic                   last;

   modport source (output valid, output node_start, output node_end, output last,
                   input ready);
   modport sink   (input valid, input node_start, input node_end, input last,
                   output ready);
endinterface

// ----- rtl/core/binary_range_split_tree_core.sv -----
// ----------------------------------------------------------------------------
// Binary range split tree core
// Bisects one index range into a full binary tree and streams its nodes
// breadth-first, root first, with the last flag on the final node.
// ----------------------------------------------------------------------------
// For each request transaction the core returns 2^(levels+1)-1 response
// transactions, one node per cycle while the response side is ready, and a
// new request is taken once the final node is in the output register.
// The rate is set by the node memory, which takes one node write per cycle,
// and by the single split unit that forms each child from its parent. A
// node with start < end splits at floor((start+end)/2); any other node is
// repeated unchanged as both children. The levels register (reset value 3)
// is written through csr_write_enable and csr_write_data; the user must write
// it only while the core is idle, which the core itself does not enforce.
// Values above the maximum depth are treated as the maximum.
module binary_range_split_tree_core
   import brst_pkg::*;
#(
   parameter int MAX_LEVELS  = BRST_MAX_LEVELS,
   parameter int INDEX_WIDTH = BRST_INDEX_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   brst_req_if.sink                     req_chan,
   brst_rsp_if.source                   rsp_chan,
   input  logic                         csr_write_enable,
   input  logic [BRST_LEVELS_WIDTH-1:0] csr_write_data
);

   localparam int NODE_W  = MAX_LEVELS + 1;
   localparam int COUNT_W = MAX_LEVELS + 2;

   logic [BRST_LEVELS_WIDTH-1:0] levels_ff;
   logic [BRST_LEVELS_WIDTH-1:0] levels_eff;
   logic [COUNT_W-1:0]           node_count;
   logic [NODE_W-1:0]            last_node;
   logic [INDEX_WIDTH-1:0]       parent_start, parent_end;
   logic [INDEX_WIDTH-1:0]       child_start, child_end;
   logic                         right_child;

   // Levels configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         levels_ff <= BRST_LEVELS_RESET;
      end else if (csr_write_enable) begin
         levels_ff <= csr_write_data;
      end
   end

   // Saturate the depth and derive the position of the final node.
   assign levels_eff = (levels_ff > BRST_LEVELS_WIDTH'(MAX_LEVELS)) ?
                       BRST_LEVELS_WIDTH'(MAX_LEVELS) : levels_ff;
   assign node_count = (COUNT_W'(1) << (levels_eff + BRST_LEVELS_WIDTH'(1)))
                       - COUNT_W'(1);
   assign last_node  = NODE_W'(node_count - COUNT_W'(1));

   brst_seq #(
      .MAX_LEVELS  (MAX_LEVELS),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .last_node    (last_node),
      .child_start  (child_start),
      .child_end    (child_end),
      .parent_start (parent_start),
      .parent_end   (parent_end),
      .right_child  (right_child)
   );

   brst_split_unit #(
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_split (
      .parent_start (parent_start),
      .parent_end   (parent_end),
      .right_child  (right_child),
      .child_start  (child_start),
      .child_end    (child_end)
   );

endmodule

// ----- rtl/core/brst_split_unit.sv -----
// ----------------------------------------------------------------------------
// Range split unit
// Computes one child range of a parent node: a compare, a midpoint add and
// an increment, shared by every node of the tree.
// ----------------------------------------------------------------------------
module brst_split_unit
   import brst_pkg::*;
#(
   parameter int INDEX_WIDTH = BRST_INDEX_WIDTH
) (
   input  logic [INDEX_WIDTH-1:0] parent_start,
   input  logic [INDEX_WIDTH-1:0] parent_end,
   input  logic                   right_child,
   output logic [INDEX_WIDTH-1:0] child_start,
   output logic [INDEX_WIDTH-1:0] child_end
);

   logic [INDEX_WIDTH:0]   sum;
   logic [INDEX_WIDTH-1:0] mid;

   // The sum is one bit wider so the midpoint never overflows.
   assign sum = {1'b0, parent_start} + {1'b0, parent_end};
   assign mid = sum[INDEX_WIDTH:1];

   // A degenerate node passes itself on; otherwise split at the midpoint.
   always_comb begin
      if (parent_start >= parent_end) begin
         child_start = parent_start;
         child_end   = parent_end;
      end else if (right_child) begin
         child_start = mid + INDEX_WIDTH'(1);
         child_end   = parent_end;
      end else begin
         child_start = parent_start;
         child_end   = mid;
      end
   end

endmodule

// ----- rtl/core/brst_seq.sv -----
// ----------------------------------------------------------------------------
// Split tree sequencer
// Walks the nodes of the tree in breadth-first order, keeps every produced
// node in a node memory for its children, and drives the output register.
// ----------------------------------------------------------------------------
module brst_seq
   import brst_pkg::*;
#(
   parameter int MAX_LEVELS  = BRST_MAX_LEVELS,
   parameter int INDEX_WIDTH = BRST_INDEX_WIDTH
) (
   input  logic                     clock,
   input  logic                     reset,
   brst_req_if.sink                 req_chan,
   brst_rsp_if.source               rsp_chan,
   input  logic [MAX_LEVELS:0]      last_node,
   input  logic [INDEX_WIDTH-1:0]   child_start,
   input  logic [INDEX_WIDTH-1:0]   child_end,
   output logic [INDEX_WIDTH-1:0]   parent_start,
   output logic [INDEX_WIDTH-1:0]   parent_end,
   output logic                     right_child
);

   localparam int NODE_W = MAX_LEVELS + 1;
   localparam int DEPTH  = 1 << NODE_W;

   brst_state_type         state_ff, state_in;
   logic [NODE_W-1:0]      wp_ff, wp_in;
   logic [NODE_W-1:0]      cur_parent;
   logic [NODE_W-1:0]      next_parent;
   logic                   step;
   logic                   accept;
   logic [INDEX_WIDTH-1:0] node_start;
   logic [INDEX_WIDTH-1:0] node_end;

   logic [INDEX_WIDTH-1:0] root_start_ff, root_end_ff;
   logic [INDEX_WIDTH-1:0] rd_start_ff, rd_end_ff;
   logic                   out_valid_ff;
   logic [INDEX_WIDTH-1:0] out_start_ff, out_end_ff;
   logic                   out_last_ff;

   logic [INDEX_WIDTH-1:0] mem_start [DEPTH];
   logic [INDEX_WIDTH-1:0] mem_end   [DEPTH];

   // Parent of node w is (w - 1) / 2; look ahead one node for the memory read.
   assign cur_parent  = (wp_ff - NODE_W'(1)) >> 1;
   assign next_parent = (wp_in - NODE_W'(1)) >> 1;

   // Children of the root come from the root register, since the root is
   // still being written when the first child needs it.
   assign parent_start = (cur_parent == '0) ? root_start_ff : rd_start_ff;
   assign parent_end   = (cur_parent == '0) ? root_end_ff   : rd_end_ff;
   assign right_child  = ~wp_ff[0];

   // Node produced in this step.
   assign node_start = (wp_ff == '0) ? root_start_ff : child_start;
   assign node_end   = (wp_ff == '0) ? root_end_ff   : child_end;

   assign accept = req_chan.valid && req_chan.ready;

   // Next state, node position and handshake.
   always_comb begin
      state_in       = state_ff;
      wp_in          = wp_ff;
      step           = 1'b0;
      req_chan.ready = 1'b0;
      unique case (state_ff)
         BRST_IDLE: begin
            // No transaction is taken while reset is held.
            req_chan.ready = !reset;
            if (req_chan.valid && !reset) begin
               state_in = BRST_RUN;
               wp_in    = '0;
            end
         end
         BRST_RUN: begin
            step = !out_valid_ff || rsp_chan.ready;
            if (step) begin
               wp_in = wp_ff + NODE_W'(1);
               if (wp_ff == last_node) begin
                  state_in = BRST_IDLE;
               end
            end
         end
         default: begin
            state_in = BRST_IDLE;
         end
      endcase
   end

   // State and position registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BRST_IDLE;
         wp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         wp_ff    <= wp_in;
      end
   end

   // Root range of the current transaction.
   always_ff @(posedge clock) begin
      if (accept) begin
         root_start_ff <= req_chan.start_index;
         root_end_ff   <= req_chan.end_index;
      end
   end

   // Node memory: one write per step, one registered read of the next parent.
   always_ff @(posedge clock) begin
      if (step) begin
         mem_start[wp_ff] <= node_start;
         mem_end[wp_ff]   <= node_end;
      end
      rd_start_ff <= mem_start[next_parent];
      rd_end_ff   <= mem_end[next_parent];
   end

   // Output register valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (step) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      if (step) begin
         out_start_ff <= node_start;
         out_end_ff   <= node_end;
         out_last_ff  <= (wp_ff == last_node);
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.node_start = out_start_ff;
   assign rsp_chan.node_end   = out_end_ff;
   assign rsp_chan.last       = out_last_ff;

endmodule

// ----- tb/sv/brst_node_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Split tree node checker
// Watches the range request and node response channels of the split tree
// core. Each accepted range is bisected breadth-first at the current depth
// into the expected node list. Each node response is compared field by field
// against the oldest expected node.
// ----------------------------------------------------------------------------
module brst_node_checker
   import brst_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   brst_req_if                          req_mon,
   brst_rsp_if                          rsp_mon,
   input  logic                         csr_write_enable,
   input  logic [BRST_LEVELS_WIDTH-1:0] csr_write_data,
   output int                           error_count,
   output int                           nodes_pending
);

   localparam int TREE_SLOTS = 2 ** (BRST_MAX_LEVELS + 1);

   typedef logic [BRST_INDEX_WIDTH-1:0] index_type;

   typedef struct packed {
      index_type node_start;
      index_type node_end;
      logic      last;
   } tree_node_type;

   logic [BRST_LEVELS_WIDTH-1:0] tree_levels;
   tree_node_type                expected_nodes[$];

   // Bisect one range into its full tree and queue the nodes in
   // breadth-first order. The children of node k sit at 2k+1 and 2k+2.
   function automatic void queue_split_tree(input index_type range_start,
                                            input index_type range_end);
      index_type                 lo[TREE_SLOTS];
      index_type                 hi[TREE_SLOTS];
      logic [BRST_INDEX_WIDTH:0] sum;
      index_type                 mid;
      int                        depth;
      int                        count;
      tree_node_type             node;
      depth = (tree_levels > BRST_MAX_LEVELS) ? BRST_MAX_LEVELS : int'(tree_levels);
      count = (1 << (depth + 1)) - 1;
      lo[0] = range_start;
      hi[0] = range_end;
      for (int k = 0; 2 * k + 2 < count; k++) begin
         if (lo[k] >= hi[k]) begin
            // A node that cannot split is repeated as both children.
            lo[2 * k + 1] = lo[k];
            hi[2 * k + 1] = hi[k];
            lo[2 * k + 2] = lo[k];
            hi[2 * k + 2] = hi[k];
         end else begin
            // The sum is one bit wider than the indices, so it cannot wrap.
            sum = {1'b0, lo[k]} + {1'b0, hi[k]};
            mid = sum[BRST_INDEX_WIDTH:1];
            lo[2 * k + 1] = lo[k];
            hi[2 * k + 1] = mid;
            lo[2 * k + 2] = mid + index_type'(1);
            hi[2 * k + 2] = hi[k];
         end
      end
      for (int k = 0; k < count; k++) begin
         node.node_start = lo[k];
         node.node_end   = hi[k];
         node.last       = (k == count - 1);
         expected_nodes.insert(expected_nodes.size(), node);
      end
   endfunction

   // Compare finished nodes first, then queue the nodes of a newly taken
   // range, and track the depth register as it is written.
   always @(posedge clock) begin : node_monitor
      tree_node_type seen;
      tree_node_type want;
      if (reset) begin
         tree_levels = BRST_LEVELS_RESET;
         expected_nodes.delete();
         error_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.node_start = rsp_mon.node_start;
            seen.node_end   = rsp_mon.node_end;
            seen.last       = rsp_mon.last;
            if (expected_nodes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected node transaction: start %0d end %0d last %0b",
                        $time, seen.node_start, seen.node_end, seen.last);
            end else begin
               want = expected_nodes.pop_front();
               if (seen != want) begin
                  error_count++;
                  if (seen.node_start != want.node_start)
                     $display("%0t: node_start mismatch: expected %0d, actual %0d",
                              $time, want.node_start, seen.node_start);
                  if (seen.node_end != want.node_end)
                     $display("%0t: node_end mismatch: expected %0d, actual %0d",
                              $time, want.node_end, seen.node_end);
                  if (seen.last != want.last)
                     $display("%0t: last mismatch: expected %0b, actual %0b",
                              $time, want.last, seen.last);
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            queue_split_tree(req_mon.start_index, req_mon.end_index);
         if (csr_write_enable)
            tree_levels = csr_write_data;
      end
      nodes_pending = expected_nodes.size();
   end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Split tree core testbench
// Drives index ranges into the core at several tree depths, first a directed
// set of corner ranges and then random ranges, with random gaps on the
// request side and random stalls on the response side. A separate checker
// predicts every node and counts failures; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
   import brst_pkg::*;

   typedef logic [BRST_INDEX_WIDTH-1:0] index_type;

   localparam index_type INDEX_TOP = {BRST_INDEX_WIDTH{1'b1}};
   localparam int        RANDOM_PHASES = 10;
   localparam int        PHASE_ITEMS = 50;

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         csr_write_enable;
   logic [BRST_LEVELS_WIDTH-1:0] csr_write_data;
   int                           error_count;
   int                           nodes_pending;
   int                           nodes_seen = 0;

   brst_req_if #(.INDEX_WIDTH(BRST_INDEX_WIDTH)) req_if ();
   brst_rsp_if #(.INDEX_WIDTH(BRST_INDEX_WIDTH)) rsp_if ();

   binary_range_split_tree_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_if),
      .rsp_chan         (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   brst_node_checker node_checker (
      .clock            (clock),
      .reset            (reset),
      .req_mon          (req_if),
      .rsp_mon          (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .nodes_pending    (nodes_pending)
   );

   // 100 MHz clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Count node transactions so the receiver knows when to apply back-pressure.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         nodes_seen <= nodes_seen + 1;
   end

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      else if (roll < 90)
         return $urandom_range(1, 3);
      else if (roll < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Offer one range after a random gap and hold it until it is taken.
   // Called and left at a falling edge.
   task automatic send_range(input index_type range_start, input index_type range_end);
      int gap;
      gap = pick_gap();
      while (gap > 0) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
         gap--;
      end
      req_if.valid       <= 1'b1;
      req_if.start_index <= range_start;
      req_if.end_index   <= range_end;
      @(posedge clock);
      while (!req_if.ready)
         @(posedge clock);
      @(negedge clock);
   endtask

   // Stop offering ranges and wait until every expected node has arrived,
   // plus a short margin for the output pipeline.
   task automatic settle();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (nodes_pending != 0)
         @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   // Write the depth register once the core has drained.
   task automatic set_levels(input logic [BRST_LEVELS_WIDTH-1:0] depth);
      settle();
      csr_write_enable <= 1'b1;
      csr_write_data   <= depth;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Random range: fully random, narrow, reversed, single index, or
   // spanning nearly the whole index space.
   task automatic random_range(output index_type range_start,
                               output index_type range_end);
      int pick;
      int span;
      pick        = $urandom_range(0, 9);
      span        = $urandom_range(0, 70);
      range_start = index_type'($urandom);
      range_end   = index_type'($urandom);
      case (pick)
         4, 5, 6: begin
            range_end = index_type'((int'(range_start) + span > int'(INDEX_TOP)) ?
                                    int'(INDEX_TOP) : int'(range_start) + span);
         end
         7: begin
            range_end = index_type'((int'(range_start) < span) ? 0 :
                                    int'(range_start) - span);
         end
         8: begin
            range_end = range_start;
         end
         9: begin
            range_start = index_type'($urandom_range(0, 3));
            range_end   = INDEX_TOP - index_type'($urandom_range(0, 3));
         end
         default: begin
         end
      endcase
   endtask

   // Response side: runs of steady ready broken by random stalls, with two
   // long holds that make the core fill up and refuse new ranges.
   initial begin : node_sink
      int run_len;
      int stall_len;
      int long_holds;
      long_holds = 0;
      rsp_if.ready = 1'b0;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200) :
                                                 $urandom_range(1, 20);
         repeat (run_len) begin
            rsp_if.ready <= 1'b1;
            @(negedge clock);
         end
         stall_len = pick_gap();
         if (long_holds < 2 && nodes_seen > 2000 + long_holds * 6000) begin
            stall_len = 500;
            long_holds++;
         end
         repeat (stall_len) begin
            rsp_if.ready <= 1'b0;
            @(negedge clock);
         end
      end
   end

   // Request side and verdict.
   initial begin : range_source
      index_type range_start;
      index_type range_end;
      logic [BRST_LEVELS_WIDTH-1:0] phase_levels[RANDOM_PHASES];
      phase_levels = '{3'd1, 3'd5, 3'd2, 3'd7, 3'd0, 3'd4, 3'd6, 3'd3, 3'd5, 3'd2};
      reset              = 1'b1;
      req_if.valid       = 1'b0;
      req_if.start_index = '0;
      req_if.end_index   = '0;
      csr_write_enable   = 1'b0;
      csr_write_data     = '0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset depth: extremes, full span, reversed, and one-wide ranges.
      send_range(16'd0, 16'd0);
      send_range(INDEX_TOP, INDEX_TOP);
      send_range(16'd0, INDEX_TOP);
      send_range(INDEX_TOP, 16'd0);
      send_range(16'd0, 16'd1);
      send_range(16'd1, 16'd0);

      // Zero levels: only the root comes back, flagged last.
      set_levels(3'd0);
      send_range(16'd0, INDEX_TOP);
      send_range(INDEX_TOP, 16'd0);
      send_range(16'd12345, 16'd12345);

      // Deepest tree, with ranges that run out of splits early.
      set_levels(BRST_LEVELS_WIDTH'(BRST_MAX_LEVELS));
      send_range(16'd0, INDEX_TOP);
      send_range(INDEX_TOP, INDEX_TOP - 16'd1);
      send_range(16'd0, 16'd62);
      send_range(16'd100, 16'd131);
      send_range(16'hAAAA, 16'h5555);
      send_range(16'h5555, 16'hAAAA);

      // Depth values above the maximum saturate.
      set_levels(3'd7);
      send_range(16'd0, INDEX_TOP);
      send_range(16'd1000, 16'd1003);
      set_levels(3'd6);
      send_range(16'd5, 16'd3);
      send_range(16'd0, 16'd31);
      send_range(INDEX_TOP - 16'd1, INDEX_TOP);

      // Random ranges, one batch per depth setting.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         set_levels(phase_levels[phase]);
         repeat (PHASE_ITEMS) begin
            random_range(range_start, range_end);
            send_range(range_start, range_end);
         end
      end

      settle();
      repeat (20) @(negedge clock);
      if (error_count == 0)
         $display("binary_range_split_tree_core test passed");
      else
         $display("binary_range_split_tree_core test failed");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run (120 ms).
   initial begin
      #120_000_000;
      $display("binary_range_split_tree_core test failed");
      $finish;
   end

endmodule

// ----- binary_range_split_tree_core.f -----
rtl/core/brst_pkg.sv
rtl/core/brst_req_if.sv
rtl/core/brst_rsp_if.sv
rtl/core/brst_split_unit.sv
rtl/core/brst_seq.sv
rtl/core/binary_range_split_tree_core.sv
tb/sv/brst_node_checker.sv
tb/sv/testbench.sv
